>>> hdl/mlcd_pkg.sv
`default_nettype none

package mlcd_pkg;

    // Number of thresholds held in the configuration registers.
    localparam int MaxLevels = 6;

    // Field widths.
    localparam int CompWidth  = 16;
    localparam int LevelWidth = 40;
    localparam int IndexWidth = 4;
    localparam int CountWidth = 3;

    // APB port geometry: 64-bit data, registers on 8-byte boundaries.
    localparam int DataWidth  = 64;
    localparam int AddrWidth  = 6;
    localparam int RegLsb     = 3;

    typedef logic signed [CompWidth-1:0]  comp_t;
    typedef logic signed [LevelWidth-1:0] level_t;
    typedef logic signed [IndexWidth-1:0] band_t;
    typedef logic        [CountWidth-1:0] count_t;

    // Band reported below the first threshold, also the reset band.
    localparam band_t BandBelow = -4'sd1;

    // Register map, by place in the list.
    typedef enum logic [AddrWidth-RegLsb-1:0] {
        REG_LEVEL_COUNT     = 3'd0,
        REG_COMPONENT_COUNT = 3'd1,
        REG_LEVEL_0         = 3'd2,
        REG_LEVEL_1         = 3'd3,
        REG_LEVEL_2         = 3'd4,
        REG_LEVEL_3         = 3'd5,
        REG_LEVEL_4         = 3'd6,
        REG_LEVEL_5         = 3'd7
    } reg_index_t;

    // Component counts that select an evaluation mode.
    localparam count_t CompScalar = 3'd1;
    localparam count_t CompTwo    = 3'd2;
    localparam count_t CompThree  = 3'd3;
    localparam count_t CompFour   = 3'd4;

endpackage

`default_nettype wire

>>> hdl/multi_level_crossing_detector_top.sv
`default_nettype none

// Channel   Direction  Handshake          Word
// s_        in         s_valid/s_ready    comp_x, comp_y, comp_z, comp_w (Q8.8)
// m_        out        m_valid/m_ready    level_changed, level_index
// APB       in         psel/penable       64-bit registers at 8-byte steps
//
// A word passes from acceptance to result through the input register, then the
// result register. One word is accepted in every cycle while no result stalls;
// the stored band is updated as each word moves into the result register.
// Reset (aresetn low, synchronous) empties both registers and sets the band to
// minus one. A stalled result holds the input register, which then stalls s_.
module multi_level_crossing_detector_top (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // Input words.
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire mlcd_pkg::comp_t                       s_comp_x,
    input  wire mlcd_pkg::comp_t                       s_comp_y,
    input  wire mlcd_pkg::comp_t                       s_comp_z,
    input  wire mlcd_pkg::comp_t                       s_comp_w,
    // Result words.
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic                                       m_level_changed,
    output mlcd_pkg::band_t                            m_level_index,
    // Configuration port.
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [mlcd_pkg::AddrWidth-1:0]        paddr,
    input  wire logic [mlcd_pkg::DataWidth-1:0]        pwdata,
    output logic      [mlcd_pkg::DataWidth-1:0]        prdata,
    output logic                                       pready
);

    // Configuration registers.
    mlcd_pkg::count_t level_count_reg;
    mlcd_pkg::count_t comp_count_reg;
    mlcd_pkg::level_t level_reg [mlcd_pkg::MaxLevels];

    mlcd_pkg::reg_index_t reg_sel;
    logic                 cfg_write;
    logic [2:0]           level_sel;

    // Pipeline registers.
    logic             in_valid_reg;
    mlcd_pkg::comp_t  in_x_reg, in_y_reg, in_z_reg, in_w_reg;
    logic             out_valid_reg;
    logic             out_changed_reg;
    mlcd_pkg::band_t  out_index_reg;
    mlcd_pkg::band_t  band_reg;
    mlcd_pkg::band_t  band_next;

    logic in_load;
    logic advance;

    // Datapath signals.
    logic signed [31:0] sq_x, sq_y, sq_z, sq_w;
    logic [32:0]        sum_sq;
    mlcd_pkg::level_t   value;
    logic               count_ok;
    logic [2:0]         n_eff;
    mlcd_pkg::level_t   first_lvl, last_lvl;
    logic               ascending;
    logic [mlcd_pkg::MaxLevels-2:0] hit;

    // APB decode; every write completes in its access cycle.
    assign pready    = 1'b1;
    assign reg_sel   = mlcd_pkg::reg_index_t'(paddr[mlcd_pkg::AddrWidth-1:mlcd_pkg::RegLsb]);
    assign cfg_write = psel && penable && pwrite;
    assign level_sel = 3'(reg_sel - mlcd_pkg::REG_LEVEL_0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_count_reg <= mlcd_pkg::count_t'(1);
            comp_count_reg  <= mlcd_pkg::CompScalar;
            for (int i = 0; i < mlcd_pkg::MaxLevels; i++) begin
                level_reg[i] <= '0;
            end
        end else if (cfg_write) begin
            unique case (reg_sel)
                mlcd_pkg::REG_LEVEL_COUNT: begin
                    level_count_reg <= pwdata[mlcd_pkg::CountWidth-1:0];
                end
                mlcd_pkg::REG_COMPONENT_COUNT: begin
                    comp_count_reg <= pwdata[mlcd_pkg::CountWidth-1:0];
                end
                default: begin
                    level_reg[level_sel] <= pwdata[mlcd_pkg::LevelWidth-1:0];
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (reg_sel)
            mlcd_pkg::REG_LEVEL_COUNT: begin
                prdata = 64'(level_count_reg);
            end
            mlcd_pkg::REG_COMPONENT_COUNT: begin
                prdata = 64'(comp_count_reg);
            end
            default: begin
                prdata = 64'(level_reg[level_sel]);
            end
        endcase
    end

    // Flow control: a word moves on when the result register is free or drains.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign in_load = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_x_reg <= s_comp_x;
            in_y_reg <= s_comp_y;
            in_z_reg <= s_comp_z;
            in_w_reg <= s_comp_w;
        end
    end

    // Squared length; each square of a Q8.8 value is non-negative.
    assign sq_x = 32'(in_x_reg) * 32'(in_x_reg);
    assign sq_y = 32'(in_y_reg) * 32'(in_y_reg);
    assign sq_z = 32'(in_z_reg) * 32'(in_z_reg);
    assign sq_w = 32'(in_w_reg) * 32'(in_w_reg);

    always_comb begin
        sum_sq = 33'($unsigned(sq_x)) + 33'($unsigned(sq_y));
        if (comp_count_reg >= mlcd_pkg::CompThree) begin
            sum_sq = sum_sq + 33'($unsigned(sq_z));
        end
        if (comp_count_reg == mlcd_pkg::CompFour) begin
            sum_sq = sum_sq + 33'($unsigned(sq_w));
        end
    end

    // The scalar is widened to Q24.16; the squared length is already Q17.16.
    always_comb begin
        if (comp_count_reg == mlcd_pkg::CompScalar) begin
            value = {{16{in_x_reg[15]}}, in_x_reg, 8'h00};
        end else begin
            value = {7'b0, sum_sq};
        end
    end

    assign count_ok = (comp_count_reg >= mlcd_pkg::CompScalar) &&
                      (comp_count_reg <= mlcd_pkg::CompFour);

    // Thresholds in use: zero counts as one, anything above the list saturates.
    always_comb begin
        if (level_count_reg == 3'd0) begin
            n_eff = 3'd1;
        end else if (level_count_reg > 3'(mlcd_pkg::MaxLevels)) begin
            n_eff = 3'(mlcd_pkg::MaxLevels);
        end else begin
            n_eff = level_count_reg;
        end
    end

    assign first_lvl = level_reg[0];
    assign last_lvl  = level_reg[3'(n_eff - 3'd1)];
    assign ascending = !(last_lvl < first_lvl);

    // Interval tests, one per adjacent pair of thresholds.
    always_comb begin
        for (int i = 0; i < mlcd_pkg::MaxLevels - 1; i++) begin
            if (3'(i + 1) < n_eff) begin
                if (ascending) begin
                    hit[i] = (value >= level_reg[i]) && (value < level_reg[i+1]);
                end else begin
                    hit[i] = (value > level_reg[i+1]) && (value <= level_reg[i]);
                end
            end else begin
                hit[i] = 1'b0;
            end
        end
    end

    // Band selection: end bands first, then the lowest matching interval wins.
    always_comb begin
        band_next = band_reg;
        if (count_ok) begin
            if (ascending) begin
                if (value < first_lvl) begin
                    band_next = mlcd_pkg::BandBelow;
                end else if (value >= last_lvl) begin
                    band_next = mlcd_pkg::band_t'({1'b0, n_eff - 3'd1});
                end
            end else begin
                if (value > first_lvl) begin
                    band_next = mlcd_pkg::BandBelow;
                end else if (value <= last_lvl) begin
                    band_next = mlcd_pkg::band_t'({1'b0, n_eff - 3'd1});
                end
            end
            for (int i = mlcd_pkg::MaxLevels - 2; i >= 0; i--) begin
                if (hit[i]) begin
                    band_next = mlcd_pkg::band_t'(i);
                end
            end
        end
    end

    // Result register and stored band.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            band_reg      <= mlcd_pkg::BandBelow;
        end else begin
            if (advance) begin
                out_valid_reg <= 1'b1;
                band_reg      <= band_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_changed_reg <= (band_next != band_reg);
            out_index_reg   <= band_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_level_changed = out_changed_reg;
    assign m_level_index   = out_index_reg;

endmodule

`default_nettype wire
